// ===== src/script_tokenizer_top_assert.svh =====
// Assertion macros shared by the tokenizer top level.
`ifndef SCRIPT_TOKENIZER_TOP_ASSERT_SVH
`define SCRIPT_TOKENIZER_TOP_ASSERT_SVH

// Same-cycle implication, checked at every clock edge out of reset.
`define STOK_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tokenizer assertion failed");

// Next-cycle implication, checked at every clock edge out of reset.
`define STOK_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tokenizer assertion failed");

`endif

// ===== src/stok_pkg.sv =====
`timescale 1ns / 1ps
package stok_pkg;

	localparam int MAX_RES   = 4;
	localparam int RES_DEPTH = 8;
	localparam int PTR_W     = $clog2(RES_DEPTH);
	localparam int CNT_W     = $clog2(RES_DEPTH + 1);
	localparam int PUSH_W    = $clog2(MAX_RES + 1);
	localparam int SLOT_W    = $clog2(MAX_RES);

	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_WS_MAX = 8'd32;

	typedef enum logic [1:0] {
		KIND_CHAR       = 2'd0,
		KIND_END        = 2'd1,
		KIND_SCRIPT_END = 2'd2
	} kind_t;

	typedef struct packed {
		logic              en;
		logic [PUSH_W-1:0] n;
	} push_t;

endpackage

// ===== src/stok_scan.sv =====
`timescale 1ns / 1ps
module stok_scan #(
	parameter int MAX_TOKEN = 256,
	parameter int LINE_BITS = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_wr_en,
	input  logic [7:0]              cfg_wr_data,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [7:0]              byte_value,
	input  logic                    last_byte,
	input  logic                    new_script,
	input  logic                    room,
	output stok_pkg::push_t         push,
	output logic [LINE_BITS+11:0]   slot [stok_pkg::MAX_RES]
);

	localparam int EW    = LINE_BITS + 12;
	localparam int LEN_W = $clog2(MAX_TOKEN);
	localparam int VEC_W = stok_pkg::MAX_RES * EW;

	typedef enum logic [2:0] {
		MODE_SKIP    = 3'd0,
		MODE_COMMENT = 3'd1,
		MODE_PLAIN   = 3'd2,
		MODE_QUOTED  = 3'd3,
		MODE_DROP    = 3'd4,
		MODE_DONE    = 3'd5
	} mode_t;

	logic                          valid_s1;
	logic [7:0]                    byte_s1;
	logic                          last_s1;
	logic                          new_script_s1;

	mode_t                         mode_q;
	logic [LEN_W-1:0]              len_q;
	logic                          crossed_q;
	logic [LINE_BITS-1:0]          line_q;
	logic                          pend_q;
	logic [7:0]                    max_len_q;

	logic                          fire;
	logic [LEN_W-1:0]              lim;

	mode_t                         m;
	logic [LEN_W-1:0]              len;
	logic                          cr;
	logic [LINE_BITS-1:0]          ln;
	logic                          pend;
	logic [stok_pkg::PUSH_W-1:0]   n;
	logic [VEC_W-1:0]              vec;
	logic                          byte_used;
	logic                          add_en;
	logic [7:0]                    add_ch;
	logic                          add_q;

	function automatic logic [EW-1:0] mk(input stok_pkg::kind_t k, input logic [7:0] c,
			input logic [LINE_BITS-1:0] l, input logic cx, input logic q);
		return {k, c, l, cx, q};
	endfunction

	assign fire     = valid_s1 && room;
	assign in_stall = valid_s1 && !room;

	always_comb begin
		if ({1'b0, max_len_q} > 9'(MAX_TOKEN - 1)) begin
			lim = LEN_W'(MAX_TOKEN - 1);
		end else if (max_len_q == 8'd0) begin
			lim = LEN_W'(1);
		end else begin
			lim = max_len_q[LEN_W-1:0];
		end
	end

	always_comb begin
		m         = mode_q;
		len       = len_q;
		cr        = crossed_q;
		ln        = line_q;
		pend      = pend_q;
		n         = '0;
		vec       = '0;
		byte_used = 1'b0;
		add_en    = 1'b0;
		add_ch    = '0;
		add_q     = 1'b0;

		if (new_script_s1) begin
			m    = MODE_SKIP;
			ln   = LINE_BITS'(1);
			cr   = 1'b0;
			len  = '0;
			pend = 1'b0;
		end

		if (m != MODE_DONE) begin
			if (pend) begin
				pend = 1'b0;
				if (byte_s1 == stok_pkg::CH_SLASH) begin
					if (m == MODE_PLAIN) begin
						vec = {vec[VEC_W-EW-1:0], mk(stok_pkg::KIND_END, 8'd0, ln, cr, 1'b0)};
						n   = n + stok_pkg::PUSH_W'(1);
						cr  = 1'b0;
						len = '0;
					end
					m         = MODE_COMMENT;
					byte_used = 1'b1;
				end else begin
					if (m != MODE_PLAIN) begin
						m   = MODE_PLAIN;
						len = '0;
					end
					vec = {vec[VEC_W-EW-1:0],
						mk(stok_pkg::KIND_CHAR, stok_pkg::CH_SLASH, ln, cr, 1'b0)};
					n   = n + stok_pkg::PUSH_W'(1);
					len = len + LEN_W'(1);
					if (len >= lim) begin
						vec = {vec[VEC_W-EW-1:0], mk(stok_pkg::KIND_END, 8'd0, ln, cr, 1'b0)};
						n   = n + stok_pkg::PUSH_W'(1);
						cr  = 1'b0;
						len = '0;
						m   = MODE_SKIP;
					end
				end
			end

			if (!byte_used) begin
				case (m)
					MODE_COMMENT: begin
						if (byte_s1 == stok_pkg::CH_NL) begin
							if (ln != '1) ln = ln + LINE_BITS'(1);
							cr = 1'b1;
							m  = MODE_SKIP;
						end
					end
					MODE_PLAIN: begin
						if (byte_s1 <= stok_pkg::CH_WS_MAX) begin
							vec = {vec[VEC_W-EW-1:0],
								mk(stok_pkg::KIND_END, 8'd0, ln, cr, 1'b0)};
							n   = n + stok_pkg::PUSH_W'(1);
							cr  = 1'b0;
							len = '0;
							m   = MODE_SKIP;
							if (byte_s1 == stok_pkg::CH_NL) begin
								if (ln != '1) ln = ln + LINE_BITS'(1);
								cr = 1'b1;
							end
						end else if (byte_s1 == stok_pkg::CH_SLASH) begin
							pend = 1'b1;
						end else begin
							add_en = 1'b1;
							add_ch = byte_s1;
						end
					end
					MODE_QUOTED: begin
						if (byte_s1 == stok_pkg::CH_QUOTE) begin
							vec = {vec[VEC_W-EW-1:0],
								mk(stok_pkg::KIND_END, 8'd0, ln, cr, 1'b1)};
							n   = n + stok_pkg::PUSH_W'(1);
							cr  = 1'b0;
							len = '0;
							m   = MODE_SKIP;
						end else begin
							add_en = 1'b1;
							add_ch = byte_s1;
							add_q  = 1'b1;
						end
					end
					MODE_DROP: begin
						m = MODE_SKIP;
					end
					MODE_DONE: begin
						m = MODE_DONE;
					end
					MODE_SKIP: begin
						if (byte_s1 <= stok_pkg::CH_WS_MAX) begin
							if (byte_s1 == stok_pkg::CH_NL) begin
								if (ln != '1) ln = ln + LINE_BITS'(1);
								cr = 1'b1;
							end
						end else if (byte_s1 == stok_pkg::CH_SLASH) begin
							pend = 1'b1;
						end else if (byte_s1 == stok_pkg::CH_QUOTE) begin
							m   = MODE_QUOTED;
							len = '0;
						end else begin
							m      = MODE_PLAIN;
							len    = '0;
							add_en = 1'b1;
							add_ch = byte_s1;
						end
					end
					default: begin
						m = MODE_SKIP;
					end
				endcase

				if (add_en) begin
					vec = {vec[VEC_W-EW-1:0], mk(stok_pkg::KIND_CHAR, add_ch, ln, cr, add_q)};
					n   = n + stok_pkg::PUSH_W'(1);
					len = len + LEN_W'(1);
					if (len >= lim) begin
						vec = {vec[VEC_W-EW-1:0], mk(stok_pkg::KIND_END, 8'd0, ln, cr, add_q)};
						n   = n + stok_pkg::PUSH_W'(1);
						cr  = 1'b0;
						len = '0;
						m   = add_q ? MODE_DROP : MODE_SKIP;
					end
				end
			end

			if (last_s1) begin
				if (pend) begin
					pend = 1'b0;
					if (m != MODE_PLAIN) begin
						m   = MODE_PLAIN;
						len = '0;
					end
					vec = {vec[VEC_W-EW-1:0],
						mk(stok_pkg::KIND_CHAR, stok_pkg::CH_SLASH, ln, cr, 1'b0)};
					n   = n + stok_pkg::PUSH_W'(1);
					len = len + LEN_W'(1);
					if (len >= lim) begin
						vec = {vec[VEC_W-EW-1:0], mk(stok_pkg::KIND_END, 8'd0, ln, cr, 1'b0)};
						n   = n + stok_pkg::PUSH_W'(1);
						cr  = 1'b0;
						len = '0;
						m   = MODE_SKIP;
					end
				end
				if (n != '0 && vec[EW-1 -: 2] == stok_pkg::KIND_END) begin
					vec[EW-1 -: 2] = stok_pkg::KIND_SCRIPT_END;
				end else begin
					vec = {vec[VEC_W-EW-1:0], mk(stok_pkg::KIND_SCRIPT_END, 8'd0, ln, cr,
						m == MODE_QUOTED)};
					n   = n + stok_pkg::PUSH_W'(1);
				end
				m   = MODE_DONE;
				len = '0;
			end
		end
	end

	always_comb begin
		for (int i = 0; i < stok_pkg::MAX_RES; i++) begin
			slot[i] = vec[stok_pkg::SLOT_W'(n - stok_pkg::PUSH_W'(1) - stok_pkg::PUSH_W'(i)) * EW
				+: EW];
		end
	end

	assign push.en = fire;
	assign push.n  = n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1       <= byte_value;
			last_s1       <= last_byte;
			new_script_s1 <= new_script;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_SKIP;
			len_q     <= '0;
			crossed_q <= 1'b0;
			line_q    <= LINE_BITS'(1);
			pend_q    <= 1'b0;
		end else if (fire) begin
			mode_q    <= m;
			len_q     <= len;
			crossed_q <= cr;
			line_q    <= ln;
			pend_q    <= pend;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= 8'd255;
		end else if (cfg_wr_en) begin
			max_len_q <= cfg_wr_data;
		end
	end

endmodule

// ===== src/stok_fifo.sv =====
`timescale 1ns / 1ps
module stok_fifo #(
	parameter int EW = 28
) (
	input  logic            clk,
	input  logic            arst_n,
	input  stok_pkg::push_t push,
	input  logic [EW-1:0]   wr_data [stok_pkg::MAX_RES],
	output logic            room,
	output logic            out_valid,
	input  logic            out_stall,
	output logic [EW-1:0]   rd_data
);

	logic [EW-1:0]                mem_q [stok_pkg::RES_DEPTH];
	logic [stok_pkg::PTR_W-1:0]   wr_ptr_q;
	logic [stok_pkg::PTR_W-1:0]   rd_ptr_q;
	logic [stok_pkg::CNT_W-1:0]   cnt_q;
	logic                         pop;
	logic [stok_pkg::CNT_W-1:0]   add_n;

	assign out_valid = cnt_q != '0;
	assign pop       = out_valid && !out_stall;
	assign rd_data   = mem_q[rd_ptr_q];
	assign room      = cnt_q <= stok_pkg::CNT_W'(stok_pkg::RES_DEPTH - stok_pkg::MAX_RES);
	assign add_n     = push.en ? stok_pkg::CNT_W'(push.n) : '0;

	always_ff @(posedge clk) begin
		for (int i = 0; i < stok_pkg::MAX_RES; i++) begin
			if (push.en && stok_pkg::PUSH_W'(i) < push.n) begin
				mem_q[wr_ptr_q + stok_pkg::PTR_W'(i)] <= wr_data[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + stok_pkg::PTR_W'(add_n);
			rd_ptr_q <= rd_ptr_q + stok_pkg::PTR_W'(pop);
			cnt_q    <= cnt_q + add_n - stok_pkg::CNT_W'(pop);
		end
	end

endmodule

// ===== src/script_tokenizer_top.sv =====
`timescale 1ns / 1ps
// Script tokenizer: one script byte in per beat, token results out one per beat.
// Input channel: byte_value, last_byte, new_script under in_valid / in_stall.
// Output channel: kind, char_value, line_number, crossed_line, was_quoted under
// out_valid / out_stall. kind 0 is a token character, 1 an end of token, 2 the
// end of the script. Configuration: cfg_wr_en writes cfg_wr_data into the
// maximum token length, no read-back.
// Path: a taken byte is registered in the scan stage, then its results go to the buffer.
// Throughput: one byte per cycle while each byte gives at most one result
// and out_stall stays low; a byte may give up to 4 results. The
// bytes are queued behind an 8-entry result buffer; input is taken while four
// entries are free, so a stalled receiver stops input after that buffer fills.
// Reset: scanning restarts at line 1 skipping whitespace, the buffer empties and
// the maximum token length returns to 255. Results held during a stall stay
// unchanged until taken.
module script_tokenizer_top #(
	parameter int MAX_TOKEN = 256,
	parameter int LINE_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [7:0]           cfg_wr_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [7:0]           byte_value,
	input  logic                 last_byte,
	input  logic                 new_script,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [1:0]           kind,
	output logic [7:0]           char_value,
	output logic [LINE_BITS-1:0] line_number,
	output logic                 crossed_line,
	output logic                 was_quoted
);

`include "script_tokenizer_top_assert.svh"

	localparam int EW = LINE_BITS + 12;

	stok_pkg::push_t push;
	logic            room;
	logic [EW-1:0]   slot [stok_pkg::MAX_RES];
	logic [EW-1:0]   rd_data;

	stok_scan #(
		.MAX_TOKEN (MAX_TOKEN),
		.LINE_BITS (LINE_BITS)
	) u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.byte_value  (byte_value),
		.last_byte   (last_byte),
		.new_script  (new_script),
		.room        (room),
		.push        (push),
		.slot        (slot)
	);

	stok_fifo #(
		.EW (EW)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wr_data   (slot),
		.room      (room),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.rd_data   (rd_data)
	);

	assign kind         = rd_data[EW-1 -: 2];
	assign char_value   = rd_data[EW-3 -: 8];
	assign line_number  = rd_data[LINE_BITS+1:2];
	assign crossed_line = rd_data[1];
	assign was_quoted   = rd_data[0];

	`STOK_ASSERT_NOW(a_push_has_room, push.en, room && push.n <= 3'd4)
	`STOK_ASSERT_NEXT(a_fill_needs_push, !out_valid && !push.en, !out_valid)
	`STOK_ASSERT_NOW(a_char_zero_off_char, out_valid && kind != stok_pkg::KIND_CHAR, char_value == 8'd0)
	`STOK_ASSERT_NOW(a_line_nonzero, out_valid, line_number != '0)

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
module tb;

	typedef enum logic [2:0] {
		SCAN_SKIP,
		SCAN_COMMENT,
		SCAN_WORD,
		SCAN_QUOTED,
		SCAN_DROP,
		SCAN_DONE
	} scan_mode_t;

	typedef struct packed {
		logic [7:0] value;
		logic       last;
		logic       restart;
	} script_beat_t;

	typedef struct packed {
		stok_pkg::kind_t kind;
		logic [7:0]      ch;
		logic [15:0]     line;
		logic            crossed;
		logic            quoted;
	} token_res_t;

	localparam logic [7:0] LIMIT_RESET = 8'd255;
	localparam logic [7:0] CH_SPACE    = 8'h20;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [7:0]  cfg_wr_data = 8'd0;
	logic        in_valid = 1'b0;
	logic [7:0]  byte_value = 8'd0;
	logic        last_byte = 1'b0;
	logic        new_script = 1'b0;
	logic        out_stall = 1'b0;
	logic        in_stall;
	logic        out_valid;
	logic [1:0]  kind;
	logic [7:0]  char_value;
	logic [15:0] line_number;
	logic        crossed_line;
	logic        was_quoted;

	script_beat_t script_beats[$];
	token_res_t   results_due[$];
	token_res_t   beat_results[$];

	scan_mode_t  scan = SCAN_SKIP;
	logic [15:0] line_cnt = 16'd1;
	logic        crossed_nl = 1'b0;
	int          tok_len = 0;
	logic        slash_held = 1'b0;
	logic [7:0]  len_limit = LIMIT_RESET;

	logic calm = 1'b0;
	logic restart_next = 1'b0;
	int   errors = 0;
	int   beats_queued = 0;

	script_tokenizer_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.byte_value(byte_value),
		.last_byte(last_byte),
		.new_script(new_script),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.kind(kind),
		.char_value(char_value),
		.line_number(line_number),
		.crossed_line(crossed_line),
		.was_quoted(was_quoted)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void add_result(stok_pkg::kind_t k, logic [7:0] c, logic q);
		token_res_t r;
		if (beat_results.size() < stok_pkg::MAX_RES) begin
			r.kind = k;
			r.ch = c;
			r.line = line_cnt;
			r.crossed = crossed_nl;
			r.quoted = q;
			beat_results.push_back(r);
		end
	endfunction

	function automatic void bump_line();
		if (line_cnt != 16'hFFFF)
			line_cnt = line_cnt + 16'd1;
		crossed_nl = 1'b1;
	endfunction

	function automatic void close_token(logic q);
		add_result(stok_pkg::KIND_END, 8'd0, q);
		crossed_nl = 1'b0;
		tok_len = 0;
		scan = SCAN_SKIP;
	endfunction

	function automatic void take_char(logic [7:0] c, logic q);
		int lim;
		lim = (len_limit == 8'd0) ? 1 : int'(len_limit);
		add_result(stok_pkg::KIND_CHAR, c, q);
		tok_len++;
		if (tok_len >= lim) begin
			close_token(q);
			if (q)
				scan = SCAN_DROP;
		end
	endfunction

	function automatic void release_slash();
		if (scan != SCAN_WORD) begin
			scan = SCAN_WORD;
			tok_len = 0;
		end
		take_char(stok_pkg::CH_SLASH, 1'b0);
	endfunction

	function automatic void scan_byte(logic [7:0] b);
		if (slash_held) begin
			slash_held = 1'b0;
			if (b == stok_pkg::CH_SLASH) begin
				if (scan == SCAN_WORD)
					close_token(1'b0);
				scan = SCAN_COMMENT;
				return;
			end
			release_slash();
		end
		case (scan)
			SCAN_COMMENT: begin
				if (b == stok_pkg::CH_NL) begin
					bump_line();
					scan = SCAN_SKIP;
				end
			end
			SCAN_WORD: begin
				if (b <= stok_pkg::CH_WS_MAX) begin
					close_token(1'b0);
					if (b == stok_pkg::CH_NL)
						bump_line();
				end else if (b == stok_pkg::CH_SLASH) begin
					slash_held = 1'b1;
				end else begin
					take_char(b, 1'b0);
				end
			end
			SCAN_QUOTED: begin
				if (b == stok_pkg::CH_QUOTE)
					close_token(1'b1);
				else
					take_char(b, 1'b1);
			end
			SCAN_DROP: scan = SCAN_SKIP;
			SCAN_DONE: ;
			default: begin
				scan = SCAN_SKIP;
				if (b <= stok_pkg::CH_WS_MAX) begin
					if (b == stok_pkg::CH_NL)
						bump_line();
				end else if (b == stok_pkg::CH_SLASH) begin
					slash_held = 1'b1;
				end else if (b == stok_pkg::CH_QUOTE) begin
					scan = SCAN_QUOTED;
					tok_len = 0;
				end else begin
					scan = SCAN_WORD;
					tok_len = 0;
					take_char(b, 1'b0);
				end
			end
		endcase
	endfunction

	function automatic void restart_scan();
		scan = SCAN_SKIP;
		line_cnt = 16'd1;
		crossed_nl = 1'b0;
		tok_len = 0;
		slash_held = 1'b0;
	endfunction

	function automatic void tokenize_beat(script_beat_t s);
		beat_results.delete();
		if (s.restart)
			restart_scan();
		if (scan == SCAN_DONE)
			return;
		scan_byte(s.value);
		if (s.last) begin
			if (slash_held) begin
				slash_held = 1'b0;
				release_slash();
			end
			if (beat_results.size() > 0
					&& beat_results[beat_results.size() - 1].kind == stok_pkg::KIND_END)
				beat_results[beat_results.size() - 1].kind = stok_pkg::KIND_SCRIPT_END;
			else
				add_result(stok_pkg::KIND_SCRIPT_END, 8'd0, scan == SCAN_QUOTED);
			scan = SCAN_DONE;
			tok_len = 0;
		end
		foreach (beat_results[i])
			results_due.push_back(beat_results[i]);
	endfunction

	function automatic void flag_error(string msg);
		if (errors < 10)
			$display("%0t ns: %s", $time, msg);
		errors++;
	endfunction

	always @(posedge clk) begin : byte_driver
		script_beat_t taken;
		script_beat_t nxt;
		if (arst_n && (!in_valid || !in_stall)) begin
			if (in_valid) begin
				taken.value = byte_value;
				taken.last = last_byte;
				taken.restart = new_script;
				tokenize_beat(taken);
			end
			if (script_beats.size() > 0 && (calm || $urandom_range(99) >= 19)) begin
				nxt = script_beats.pop_front();
				in_valid <= 1'b1;
				byte_value <= nxt.value;
				last_byte <= nxt.last;
				new_script <= nxt.restart;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin : result_check
		token_res_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (results_due.size() == 0) begin
				flag_error($sformatf("unexpected beat: kind %0d char %h line %0d",
					kind, char_value, line_number));
			end else begin
				want = results_due.pop_front();
				if (kind != want.kind || char_value != want.ch || line_number != want.line
						|| crossed_line != want.crossed || was_quoted != want.quoted)
					flag_error($sformatf({"mismatch exp/got: kind %0d/%0d char %h/%h ",
						"line %0d/%0d crossed %b/%b quoted %b/%b"},
						want.kind, kind, want.ch, char_value, want.line, line_number,
						want.crossed, crossed_line, want.quoted, was_quoted));
			end
		end
		out_stall <= !calm && ($urandom_range(99) < 19);
	end

	function automatic void queue_byte(logic [7:0] v, logic fin = 1'b0);
		script_beat_t s;
		s.value = v;
		s.last = fin;
		s.restart = restart_next;
		script_beats.push_back(s);
		restart_next = 1'b0;
		beats_queued++;
	endfunction

	function automatic void queue_script();
		int pieces;
		int n;
		int r;
		logic [7:0] c;
		script_beat_t junk;
		restart_next = 1'b1;
		pieces = $urandom_range(1, 8);
		repeat (pieces) begin
			r = $urandom_range(99);
			if (r < 25) begin
				c = ($urandom_range(1) == 0) ? CH_SPACE : 8'($urandom_range(0, 32));
				if ($urandom_range(2) == 0)
					c = stok_pkg::CH_NL;
				queue_byte(c);
			end else if (r < 50) begin
				n = $urandom_range(1, 8);
				repeat (n)
					queue_byte(($urandom_range(9) == 0) ? stok_pkg::CH_SLASH
						: 8'($urandom_range(33, 255)));
			end else if (r < 65) begin
				queue_byte(stok_pkg::CH_QUOTE);
				n = $urandom_range(0, 8);
				repeat (n) begin
					c = 8'($urandom_range(0, 255));
					if (c == stok_pkg::CH_QUOTE)
						c = stok_pkg::CH_NL;
					queue_byte(c);
				end
				if ($urandom_range(4) != 0)
					queue_byte(stok_pkg::CH_QUOTE);
			end else if (r < 75) begin
				queue_byte(stok_pkg::CH_SLASH);
				queue_byte(stok_pkg::CH_SLASH);
				n = $urandom_range(0, 6);
				repeat (n) begin
					c = 8'($urandom_range(0, 255));
					if (c == stok_pkg::CH_NL)
						c = 8'h41;
					queue_byte(c);
				end
				queue_byte(stok_pkg::CH_NL);
			end else if (r < 82) begin
				queue_byte(stok_pkg::CH_SLASH);
			end else if (r < 92) begin
				queue_byte(8'($urandom_range(0, 255)));
			end else begin
				restart_next = 1'b1;
			end
		end
		r = $urandom_range(3);
		if (r == 0)
			c = stok_pkg::CH_SLASH;
		else if (r == 1)
			c = CH_SPACE;
		else
			c = 8'($urandom_range(0, 255));
		queue_byte(c, 1'b1);
		if ($urandom_range(9) == 0) begin
			n = $urandom_range(1, 3);
			repeat (n) begin
				junk.value = 8'($urandom_range(0, 255));
				junk.last = 1'($urandom_range(1));
				junk.restart = 1'b0;
				script_beats.push_back(junk);
			end
		end
	endfunction

	task automatic wait_idle();
		do
			@(negedge clk);
		while (script_beats.size() > 0 || in_valid || results_due.size() > 0);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_limit(logic [7:0] v);
		wait_idle();
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		len_limit = v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(negedge clk);
	endtask

	initial begin : stimulus
		int i;
		int target;
		logic [7:0] limits [6];
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// plain, slash, comment, quoted, empty quoted, held slash at script end
		queue_byte(8'h61);
		queue_byte(8'hFF);
		queue_byte(8'h00);
		queue_byte(stok_pkg::CH_SLASH);
		queue_byte(8'h78);
		queue_byte(stok_pkg::CH_SLASH);
		queue_byte(stok_pkg::CH_SLASH);
		queue_byte(8'h7A);
		queue_byte(stok_pkg::CH_NL);
		queue_byte(stok_pkg::CH_QUOTE);
		queue_byte(stok_pkg::CH_NL);
		queue_byte(8'h80);
		queue_byte(stok_pkg::CH_QUOTE);
		queue_byte(stok_pkg::CH_QUOTE);
		queue_byte(stok_pkg::CH_QUOTE);
		queue_byte(8'h21);
		queue_byte(CH_SPACE);
		queue_byte(stok_pkg::CH_SLASH, 1'b1);
		queue_byte(8'h71);
		// restart mid-token, open quote at script end, end token folded into script end
		restart_next = 1'b1;
		queue_byte(8'h6B);
		restart_next = 1'b1;
		queue_byte(8'h6D);
		queue_byte(CH_SPACE);
		queue_byte(stok_pkg::CH_QUOTE);
		queue_byte(8'h71, 1'b1);
		restart_next = 1'b1;
		queue_byte(8'h65);
		queue_byte(CH_SPACE, 1'b1);

		// one-character tokens: cut, drop after quoted cut
		write_limit(8'd1);
		restart_next = 1'b1;
		queue_byte(stok_pkg::CH_QUOTE);
		queue_byte(8'h61);
		queue_byte(stok_pkg::CH_NL);
		queue_byte(8'h78);
		queue_byte(8'h79);
		queue_byte(stok_pkg::CH_QUOTE);
		queue_byte(8'h63);
		queue_byte(stok_pkg::CH_QUOTE);
		queue_byte(stok_pkg::CH_SLASH);
		queue_byte(stok_pkg::CH_SLASH, 1'b1);

		limits[0] = 8'd1;
		limits[1] = 8'd2;
		limits[2] = 8'd3;
		limits[3] = 8'd0;
		limits[4] = 8'($urandom_range(4, 254));
		limits[5] = LIMIT_RESET;
		for (i = 0; i < 6; i++) begin
			write_limit(limits[i]);
			calm = (i == 2);
			target = beats_queued + 45;
			while (beats_queued < target)
				queue_script();
		end
		wait_idle();
		calm = 1'b0;
		repeat (8) @(negedge clk);
		if (errors == 0 && results_due.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+src
src/stok_pkg.sv
src/stok_scan.sv
src/stok_fifo.sv
src/script_tokenizer_top.sv
tb/sv/tb.sv
